FILE: hdl/lbs_pkg.sv
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared constants and types for the linear blend skinning core.
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int MAX_BONES_DEF = 64;
    localparam int INFLUENCES    = 4;
    localparam int ELEMS         = 12;   // 3 rows x 4 columns per bone
    localparam int ROWS          = 3;
    localparam int COLS          = 4;

    localparam logic [16:0] WEIGHT_ONE = 17'd65536;

    // operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_SKIN = 1'b1;

    // datapath widths
    localparam int DEN_W      = 19;               // total weight, up to 4 * 65536
    localparam int ACC_W      = 51;               // weighted sum, signed
    localparam int NUM_W      = 52;               // rounded magnitude, padded
    localparam int DIV_BITS   = 4;                // quotient bits per stage
    localparam int DIV_STAGES = NUM_W / DIV_BITS;

    // side data that travels with each vertex word
    typedef struct packed {
        logic [2:0][31:0]  pos;
        logic              pass;
        logic [2:0]        neg;
        logic [DEN_W-1:0]  den;
    } meta_t;

endpackage

FILE: hdl/linear_blend_skinning_core.sv
// ----------------------------------------------------------------------------
// linear_blend_skinning_core
// Four-influence linear blend skinning of Q16.16 vertices against a table of
// per-bone 3x4 affine matrices, with a rounding divide by the total weight.
// ----------------------------------------------------------------------------
// One vertex word is taken every cycle while the output side does not stall;
// its path runs through the matrix read register, the matrix multiply,
// weighting and summing stages, the pipelined restoring divider that retires
// four quotient bits per stage, and the output register. A load word writes
// one matrix element in the cycle it is taken and gives no result; a vertex
// taken in the next cycle already sees it.
// The matrix table is kept as 48 banks (four influence copies of the twelve
// elements) of MAX_BONES words each, so all four bones are read in the same cycle.
// The table is not cleared at reset: every element must be loaded before a
// vertex uses it. Each stage holds its word under a stall, so the block keeps
// accepting words until the pipeline is full.
module linear_blend_skinning_core
    import lbs_pkg::*;
#(
    parameter int MAX_BONES = MAX_BONES_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               operation,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic [5:0]         bone_a,
    input  logic [5:0]         bone_b,
    input  logic [5:0]         bone_c,
    input  logic [5:0]         bone_d,
    input  logic [16:0]        weight_a,
    input  logic [16:0]        weight_b,
    input  logic [16:0]        weight_c,
    input  logic [16:0]        weight_d,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic               passed_through
);

    localparam int AW       = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
    localparam int ST_RD    = 0;
    localparam int ST_MUL   = 1;
    localparam int ST_CRD   = 2;
    localparam int ST_WMUL  = 3;
    localparam int ST_ACC   = 4;
    localparam int ST_NUM   = 5;
    localparam int ST_DIV0  = 6;
    localparam int ST_OUT   = ST_DIV0 + DIV_STAGES;
    localparam int NS       = ST_OUT + 1;

    localparam logic signed [49:0] S50_MAX = 50'sd2147483647;
    localparam logic signed [49:0] S50_MIN = -50'sd2147483648;

    // pipeline control
    logic [NS-1:0] v_reg;
    logic [NS-1:0] v_next;
    logic [NS-1:0] en;
    logic          accept;
    logic          skin_enable_reg;

    // input unpacking
    logic [5:0]    bone_in [INFLUENCES];
    logic [16:0]   w_in    [INFLUENCES];
    logic [16:0]   w_sat   [INFLUENCES];
    logic          inc_in  [INFLUENCES];
    logic [AW-1:0] rd_addr [INFLUENCES];
    logic [7:0]    wr_ext;
    logic [AW-1:0] wr_addr;
    logic          ld_we;

    // stage registers
    meta_t              meta_reg  [NS];
    meta_t              meta_next [NS];
    logic [31:0]        mat_rd    [INFLUENCES][ELEMS];
    logic [16:0]        w0_reg    [INFLUENCES];
    logic               inc0_reg  [INFLUENCES];
    logic signed [63:0] prod1_reg [INFLUENCES][ROWS][3];
    logic [31:0]        trans1_reg[INFLUENCES][ROWS];
    logic [16:0]        w1_reg    [INFLUENCES];
    logic               inc1_reg  [INFLUENCES];
    logic signed [31:0] coord_next[INFLUENCES][ROWS];
    logic signed [31:0] coord2_reg[INFLUENCES][ROWS];
    logic [16:0]        w2_reg    [INFLUENCES];
    logic               inc2_reg  [INFLUENCES];
    logic signed [48:0] wp3_reg   [INFLUENCES][ROWS];
    logic [DEN_W-1:0]   total_next;
    logic signed [ACC_W-1:0] acc4_reg [ROWS];
    logic [NUM_W-1:0]   num5_reg  [ROWS];
    logic [NUM_W-1:0]   num_next  [ROWS];
    logic [2:0]         neg_next;
    logic [NUM_W-1:0]   div_n_reg [DIV_STAGES][ROWS];
    logic [DEN_W-1:0]   div_r_reg [DIV_STAGES][ROWS];
    logic [NUM_W-1:0]   div_n_next[DIV_STAGES][ROWS];
    logic [DEN_W-1:0]   div_r_next[DIV_STAGES][ROWS];
    logic [31:0]        res_next  [ROWS];
    logic [31:0]        res_reg   [ROWS];

    // stage enables: a stage loads when it is empty or the next one loads
    always_comb
    begin
        en[NS-1] = !v_reg[NS-1] || out_ready;
        for (int i = NS - 2; i >= 0; i--)
        begin
            en[i] = !v_reg[i] || en[i+1];
        end
    end

    assign in_ready = en[ST_RD];
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        v_next[0] = accept && (operation == OP_SKIN);
        for (int i = 1; i < NS; i++)
        begin
            v_next[i] = v_reg[i-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (en[i])
                begin
                    v_reg[i] <= v_next[i];
                end
            end
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skin_enable_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            skin_enable_reg <= cfg_wdata;
        end
    end

    // unpack influences, clamp weights, qualify bones
    assign bone_in[0] = bone_a;
    assign bone_in[1] = bone_b;
    assign bone_in[2] = bone_c;
    assign bone_in[3] = bone_d;
    assign w_in[0]    = weight_a;
    assign w_in[1]    = weight_b;
    assign w_in[2]    = weight_c;
    assign w_in[3]    = weight_d;

    always_comb
    begin
        logic [7:0] ext;
        for (int k = 0; k < INFLUENCES; k++)
        begin
            ext        = {2'b00, bone_in[k]};
            rd_addr[k] = ext[AW-1:0];
            w_sat[k]   = (w_in[k] > WEIGHT_ONE) ? WEIGHT_ONE : w_in[k];
            inc_in[k]  = skin_enable_reg && ({3'b000, bone_in[k]} < 9'(MAX_BONES))
                         && (w_sat[k] != '0);
        end
    end

    // decode a matrix load
    assign wr_ext  = {2'b00, bone_a};
    assign wr_addr = wr_ext[AW-1:0];
    assign ld_we   = accept && (operation == OP_LOAD)
                     && ({3'b000, bone_a} < 9'(MAX_BONES)) && (bone_b < 6'(ELEMS));

    // matrix banks: one copy per influence, one bank per element
    for (genvar gk = 0; gk < INFLUENCES; gk++)
    begin : g_infl
        for (genvar ge = 0; ge < ELEMS; ge++)
        begin : g_elem
            logic [31:0] mem [MAX_BONES];
            logic [31:0] rd_reg;

            always_ff @(posedge clk)
            begin
                if (ld_we && (bone_b == 6'(ge)))
                begin
                    mem[wr_addr] <= pos_x;
                end
                if (en[ST_RD])
                begin
                    rd_reg <= mem[rd_addr[gk]];
                end
            end

            assign mat_rd[gk][ge] = rd_reg;
        end
    end

    // side data per stage
    always_comb
    begin
        meta_next[0].pos  = {pos_z, pos_y, pos_x};
        meta_next[0].pass = 1'b0;
        meta_next[0].neg  = '0;
        meta_next[0].den  = '0;
        for (int i = 1; i < NS; i++)
        begin
            meta_next[i] = meta_reg[i-1];
            if (i == ST_WMUL)
            begin
                meta_next[i].den  = total_next;
                meta_next[i].pass = (total_next == '0);
            end
            if (i == ST_NUM)
            begin
                meta_next[i].neg = neg_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (en[i])
            begin
                meta_reg[i] <= meta_next[i];
            end
        end
    end

    // hold weights and qualifiers beside the matrix read
    always_ff @(posedge clk)
    begin
        if (en[ST_RD])
        begin
            w0_reg   <= w_sat;
            inc0_reg <= inc_in;
        end
    end

    // multiply matrix columns by coordinates
    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            for (int k = 0; k < INFLUENCES; k++)
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    for (int c = 0; c < 3; c++)
                    begin
                        prod1_reg[k][r][c] <= $signed(mat_rd[k][r*COLS+c])
                                              * $signed(meta_reg[ST_RD].pos[c]);
                    end
                    trans1_reg[k][r] <= mat_rd[k][r*COLS+3];
                end
            end
            w1_reg   <= w0_reg;
            inc1_reg <= inc0_reg;
        end
    end

    // round products, add translation, saturate
    always_comb
    begin
        logic signed [63:0] rnd [3];
        logic signed [49:0] sum;
        for (int k = 0; k < INFLUENCES; k++)
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    rnd[c] = (prod1_reg[k][r][c] + 64'sd32768) >>> 16;
                end
                sum = 50'(rnd[0]) + 50'(rnd[1]) + 50'(rnd[2])
                      + 50'($signed(trans1_reg[k][r]));
                if (sum > S50_MAX)
                begin
                    coord_next[k][r] = 32'sh7FFFFFFF;
                end
                else if (sum < S50_MIN)
                begin
                    coord_next[k][r] = 32'sh80000000;
                end
                else
                begin
                    coord_next[k][r] = sum[31:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_CRD])
        begin
            coord2_reg <= coord_next;
            w2_reg     <= w1_reg;
            inc2_reg   <= inc1_reg;
        end
    end

    // weight each bone coordinate, drop unused influences
    always_comb
    begin
        total_next = '0;
        for (int k = 0; k < INFLUENCES; k++)
        begin
            if (inc2_reg[k])
            begin
                total_next = total_next + DEN_W'(w2_reg[k]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_WMUL])
        begin
            for (int k = 0; k < INFLUENCES; k++)
            begin
                for (int r = 0; r < ROWS; r++)
                begin
                    wp3_reg[k][r] <= inc2_reg[k]
                                     ? coord2_reg[k][r] * $signed({1'b0, w2_reg[k]})
                                     : 49'sd0;
                end
            end
        end
    end

    // sum the weighted coordinates
    always_ff @(posedge clk)
    begin
        if (en[ST_ACC])
        begin
            for (int r = 0; r < ROWS; r++)
            begin
                acc4_reg[r] <= ACC_W'(wp3_reg[0][r]) + ACC_W'(wp3_reg[1][r])
                               + ACC_W'(wp3_reg[2][r]) + ACC_W'(wp3_reg[3][r]);
            end
        end
    end

    // take magnitude and add half the divisor
    always_comb
    begin
        logic signed [ACC_W-1:0] mag;
        for (int r = 0; r < ROWS; r++)
        begin
            neg_next[r] = acc4_reg[r][ACC_W-1];
            mag         = neg_next[r] ? -acc4_reg[r] : acc4_reg[r];
            num_next[r] = NUM_W'(unsigned'(mag)) + NUM_W'(meta_reg[ST_ACC].den >> 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_NUM])
        begin
            num5_reg <= num_next;
        end
    end

    // restoring divider, four quotient bits per stage
    always_comb
    begin
        logic [NUM_W-1:0] n;
        logic [DEN_W:0]   rw;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        for (int d = 0; d < DIV_STAGES; d++)
        begin
            den = meta_reg[ST_DIV0+d-1].den;
            for (int r = 0; r < ROWS; r++)
            begin
                if (d == 0)
                begin
                    n   = num5_reg[r];
                    rem = '0;
                end
                else
                begin
                    n   = div_n_reg[d-1][r];
                    rem = div_r_reg[d-1][r];
                end
                for (int b = 0; b < DIV_BITS; b++)
                begin
                    rw = {rem, n[NUM_W-1]};
                    n  = {n[NUM_W-2:0], 1'b0};
                    if (rw >= {1'b0, den})
                    begin
                        rw   = rw - {1'b0, den};
                        n[0] = 1'b1;
                    end
                    rem = rw[DEN_W-1:0];
                end
                div_n_next[d][r] = n;
                div_r_next[d][r] = rem;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int d = 0; d < DIV_STAGES; d++)
        begin
            if (en[ST_DIV0+d])
            begin
                div_n_reg[d] <= div_n_next[d];
                div_r_reg[d] <= div_r_next[d];
            end
        end
    end

    // apply sign, saturate, or pass the position through
    always_comb
    begin
        logic [NUM_W-1:0] q;
        for (int r = 0; r < ROWS; r++)
        begin
            q = div_n_reg[DIV_STAGES-1][r];
            if (meta_reg[ST_OUT-1].pass)
            begin
                res_next[r] = meta_reg[ST_OUT-1].pos[r];
            end
            else if (meta_reg[ST_OUT-1].neg[r])
            begin
                res_next[r] = (q > NUM_W'(33'h080000000)) ? 32'h80000000
                                                           : 32'(NUM_W'(0) - q);
            end
            else
            begin
                res_next[r] = (q > NUM_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : q[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid      = v_reg[ST_OUT];
    assign out_x          = res_reg[0];
    assign out_y          = res_reg[1];
    assign out_z          = res_reg[2];
    assign passed_through = meta_reg[ST_OUT].pass;

    // a taken vertex word enters the pipe, a load word never does
    a_entry : assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (v_reg[ST_RD] == $past(operation == OP_SKIN)))
        else $error("vertex word entry mismatch");

    // a stalled output keeps the word behind it
    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NS-1] && v_reg[NS-2] && !out_ready) |=> (v_reg[NS-1] && v_reg[NS-2]))
        else $error("word lost behind stalled output");

    // a divided result always had a nonzero total weight
    a_den : assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !passed_through) |-> (meta_reg[ST_OUT].den != '0))
        else $error("divided result with zero total weight");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the skinning core: matrix loads and vertex words are driven through
// a valid/ready port with random gaps, each result is compared against a
// preset or built-in fixed point predicted value; a long output stall fills the pipe.
// ----------------------------------------------------------------------------
module tb_top
    import lbs_pkg::*;
;

    localparam int NB = MAX_BONES_DEF;

    typedef struct {
        logic        op;
        logic [31:0] px, py, pz;
        logic [5:0]  ba, bb, bc, bd;
        logic [16:0] wa, wb, wc, wd;
        bit          known;
        logic [31:0] ex, ey, ez;
        logic        ep;
    } word_t;

    typedef struct {
        logic [31:0] x, y, z;
        logic        pt;
    } skin_res_t;

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0, cfg_wdata = 0;
    logic in_valid = 0, in_ready;
    logic operation = 0;
    logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
    logic [5:0] bone_a = 0, bone_b = 0, bone_c = 0, bone_d = 0;
    logic [16:0] weight_a = 0, weight_b = 0, weight_c = 0, weight_d = 0;
    logic out_valid, out_ready = 0;
    logic signed [31:0] out_x, out_y, out_z;
    logic passed_through;

    logic [31:0] mat [NB*ELEMS];
    logic        skin_on;
    skin_res_t   pending_q [$];
    int          errors = 0;
    bit          hold_long = 0;

    linear_blend_skinning_core uut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .bone_a(bone_a), .bone_b(bone_b), .bone_c(bone_c), .bone_d(bone_d),
        .weight_a(weight_a), .weight_b(weight_b), .weight_c(weight_c),
        .weight_d(weight_d), .out_valid(out_valid), .out_ready(out_ready),
        .out_x(out_x), .out_y(out_y), .out_z(out_z),
        .passed_through(passed_through)
    );

    always #2 clk = ~clk;

    // global limit
    initial
    begin
        #20ms;
        $display("linear_blend_skinning_core test failed");
        $finish;
    end

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // per-bone transformed coordinate, products rounded half up
    function automatic longint bone_row(int b, int r, longint p [3]);
        longint t;
        longint prod;
        t = longint'($signed(mat[b*ELEMS + r*COLS + 3]));
        for (int c = 0; c < 3; c++)
        begin
            prod = longint'($signed(mat[b*ELEMS + r*COLS + c])) * p[c] + 32768;
            t += prod >>> 16;
        end
        return sat32(t);
    endfunction

    // expected result of one vertex word
    function automatic skin_res_t skin_vertex(word_t w);
        skin_res_t res;
        longint p [3];
        longint acc [3];
        longint tot, wt, mag, q;
        logic [5:0]  bi [4];
        logic [16:0] wi [4];
        p[0] = longint'($signed(w.px));
        p[1] = longint'($signed(w.py));
        p[2] = longint'($signed(w.pz));
        bi = '{w.ba, w.bb, w.bc, w.bd};
        wi = '{w.wa, w.wb, w.wc, w.wd};
        acc = '{0, 0, 0};
        tot = 0;
        if (skin_on)
        begin
            for (int k = 0; k < 4; k++)
            begin
                wt = (wi[k] > WEIGHT_ONE) ? 65536 : longint'(wi[k]);
                if (bi[k] >= NB || wt == 0) continue;
                for (int r = 0; r < 3; r++)
                    acc[r] += bone_row(int'(bi[k]), r, p) * wt;
                tot += wt;
            end
        end
        if (tot == 0)
        begin
            res.x = w.px; res.y = w.py; res.z = w.pz; res.pt = 1;
        end
        else
        begin
            for (int r = 0; r < 3; r++)
            begin
                mag = acc[r] < 0 ? -acc[r] : acc[r];
                q = (mag + tot / 2) / tot;
                p[r] = sat32(acc[r] < 0 ? -q : q);
            end
            res.x = 32'(p[0]); res.y = 32'(p[1]); res.z = 32'(p[2]); res.pt = 0;
        end
        return res;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    endtask

    task automatic tick_gap(int n);
        repeat (n) @(negedge clk);
    endtask

    // drive one word from a falling edge; update the predictor at acceptance
    task automatic send(word_t w);
        skin_res_t res;
        int gap;
        in_valid <= 1;
        operation <= w.op;
        pos_x <= w.px; pos_y <= w.py; pos_z <= w.pz;
        bone_a <= w.ba; bone_b <= w.bb; bone_c <= w.bc; bone_d <= w.bd;
        weight_a <= w.wa; weight_b <= w.wb; weight_c <= w.wc; weight_d <= w.wd;
        do @(posedge clk); while (!in_ready);
        if (w.op == OP_LOAD)
        begin
            if (w.ba < NB && w.bb < ELEMS)
                mat[w.ba*ELEMS + w.bb] = w.px;
        end
        else
        begin
            if (w.known)
            begin
                res.x = w.ex; res.y = w.ey; res.z = w.ez; res.pt = w.ep;
            end
            else
                res = skin_vertex(w);
            pending_q = {pending_q, res};
        end
        @(negedge clk);
        gap = $urandom_range(0, 4);
        if (gap != 0)
        begin
            in_valid <= 0;
            tick_gap(gap);
        end
    endtask

    // drop valid, wait for drain, then write the enable register
    task automatic set_enable(logic v);
        in_valid <= 0;
        while (pending_q.size() != 0) @(negedge clk);
        tick_gap(25);
        cfg_we <= 1; cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 0;
        skin_on = v;
    endtask

    function automatic word_t load_w(int b, int e, logic [31:0] v);
        word_t w;
        w = '{default: 0};
        w.op = OP_LOAD; w.ba = 6'(b); w.bb = 6'(e); w.px = v;
        w.py = $urandom; w.pz = $urandom;
        return w;
    endfunction

    function automatic word_t vtx(logic [31:0] x, y, z, logic [5:0] a, b, c, d,
                                  logic [16:0] wa, wb, wc, wd);
        word_t w;
        w = '{default: 0};
        w.op = OP_SKIN; w.px = x; w.py = y; w.pz = z;
        w.ba = a; w.bb = b; w.bc = c; w.bd = d;
        w.wa = wa; w.wb = wb; w.wc = wc; w.wd = wd;
        return w;
    endfunction

    function automatic logic [31:0] rnd_val();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [16:0] rnd_wt();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return WEIGHT_ONE;
            2: return 17'($urandom);  // includes over-range weights
            default: return 17'($urandom_range(0, 65536));
        endcase
    endfunction

    // receiver: a random wait before each word plus one long hold-off
    initial
    begin
        int gap;
        out_ready = 0;
        @(negedge clk);
        forever
        begin
            if (hold_long)
            begin
                out_ready <= 0;
                repeat (200) @(negedge clk);
                hold_long = 0;
            end
            gap = $urandom_range(0, 4);
            if (gap != 0)
            begin
                out_ready <= 0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1;
            do @(posedge clk); while (!(rst_n && out_valid));
            @(negedge clk);
        end
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin
        skin_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_q.size() == 0)
            begin
                errors++;
                $display("unexpected result word at %0t", $realtime);
            end
            else
            begin
                e = pending_q.pop_front();
                if (out_x !== e.x) report("out_x", out_x, e.x);
                if (out_y !== e.y) report("out_y", out_y, e.y);
                if (out_z !== e.z) report("out_z", out_z, e.z);
                if (passed_through !== e.pt)
                    report("passed_through", 32'(passed_through), 32'(e.pt));
            end
        end
    end

    initial
    begin
        word_t table_q [$];
        word_t w;
        skin_on = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1;
        tick_gap(2);

        // directed: pass-through with enable at reset value
        w = vtx(32'h7fff_ffff, 32'h8000_0000, 0, 63, 63, 63, 63, 17'h1ffff, 0, 0, 0);
        w.known = 1; w.ex = 32'h7fff_ffff; w.ey = 32'h8000_0000; w.ez = 0; w.ep = 1;
        table_q = {table_q, w};
        foreach (table_q[i]) send(table_q[i]);
        table_q.delete();

        // load every matrix: identity for bone 0, random elsewhere
        for (int b = 0; b < NB; b++)
            for (int e = 0; e < ELEMS; e++)
                send(load_w(b, e, b == 0 ? ((e % 5 == 0) ? 32'h0001_0000 : 0)
                                         : rnd_val()));
        // ignored loads
        send(load_w(5, 12, $urandom));
        send(load_w(5, 63, $urandom));

        set_enable(1);
        // directed skin rows
        w = vtx(32'h0003_0000, 32'hfffe_0000, 32'h0000_8000, 0, 0, 0, 0,
                WEIGHT_ONE, 0, 0, 0);
        w.known = 1; w.ex = 32'h0003_0000; w.ey = 32'hfffe_0000; w.ez = 32'h0000_8000;
        w.ep = 0;
        table_q = {table_q, w};
        w = vtx(32'h1234_5678, 1, 2, 1, 2, 3, 4, 0, 0, 0, 0);
        w.known = 1; w.ex = 32'h1234_5678; w.ey = 1; w.ez = 2; w.ep = 1;
        table_q = {table_q, w};
        table_q = {table_q, vtx(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 63, 62, 61,
                                60, WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE, WEIGHT_ONE)};
        table_q = {table_q, vtx(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 7, 8, 9,
                                10, 17'h1ffff, 1, 3, 17'h10001)};
        table_q = {table_q, vtx(32'hffff_ffff, 32'h0000_0001, 32'h8000_0000, 1, 1, 1,
                                1, 1, 1, 1, 1)};
        table_q = {table_q, vtx(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 12, 33, 0,
                                45, 21845, 21845, 0, 21846)};
        foreach (table_q[i]) send(table_q[i]);

        // random: mostly vertices, some reloads, a few phase changes
        for (int n = 0; n < 680; n++)
        begin
            if (n == 150) hold_long = 1;
            if (n == 350) set_enable(0);
            if (n == 420) set_enable(1);
            if ($urandom_range(0, 9) == 0)
                send(load_w($urandom_range(0, 63), $urandom_range(0, 15), rnd_val()));
            else
                send(vtx(rnd_val(), rnd_val(), rnd_val(), 6'($urandom), 6'($urandom),
                         6'($urandom), 6'($urandom),
                         rnd_wt(), rnd_wt(), rnd_wt(), rnd_wt()));
        end

        in_valid <= 0;
        while (pending_q.size() != 0) @(negedge clk);
        tick_gap(30);
        if (errors == 0)
            $display("linear_blend_skinning_core test passed");
        else
            $display("linear_blend_skinning_core test failed");
        $finish;
    end
endmodule

FILE: filelist.f
hdl/lbs_pkg.sv
hdl/linear_blend_skinning_core.sv
tb/tb_top.sv
